// ----- src/dss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the drum step sequencer.
// ----------------------------------------------------------------------------
package dss_pkg;

	localparam logic [7:0]  MARKER_VALID = 8'h69;
	localparam logic [7:0]  TEMPO_RESET  = 8'd64;
	localparam logic [15:0] NOISE_SEED   = 16'd31337;
	localparam logic [8:0]  STEP_SCALE   = 9'd256;
	localparam logic [3:0]  DIV_STEPS    = 4'd9;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;

	// one classified input item
	typedef struct packed {
		logic       is_cmd;
		logic       marker_ok;
		logic [7:0] pattern;
		logic [7:0] tempo;
	} item_t;

	// one result item
	typedef struct packed {
		logic [7:0] step_number;
		logic       tom_on;
		logic       hat_on;
		logic       snare_on;
		logic       bass_on;
		logic       noise_out;
		logic       bar_marker;
		logic       step_began;
		logic       store_cleared;
	} result_t;

endpackage
`default_nettype wire

// ----- src/dss_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dss_front
// Input stage: registers an item and tags it as tick or command.
// ----------------------------------------------------------------------------
module dss_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          action,
	input  wire logic [7:0]    cmd_marker,
	input  wire logic [7:0]    cmd_pattern,
	input  wire logic [7:0]    cmd_tempo,
	output logic               push_valid,
	output dss_pkg::item_t     push_item,
	input  wire logic          push_ready
);

	logic           valid_s1;
	dss_pkg::item_t item_s1;

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.is_cmd    <= action;
			item_s1.marker_ok <= (cmd_marker == dss_pkg::MARKER_VALID);
			item_s1.pattern   <= cmd_pattern;
			item_s1.tempo     <= cmd_tempo;
		end
	end

endmodule
`default_nettype wire

// ----- src/dss_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dss_queue
// Two-entry item queue between the front and the back.
// ----------------------------------------------------------------------------
module dss_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	input  wire dss_pkg::item_t push_item,
	output logic               push_ready,
	output logic               pop_valid,
	output dss_pkg::item_t     pop_item,
	input  wire logic          pop
);

	dss_pkg::item_t                entry_q [dss_pkg::QDEPTH];
	logic [dss_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [dss_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [dss_pkg::QPTR_W:0]      count_q;
	logic                          do_push;
	logic                          do_pop;

	assign push_ready = (count_q != (dss_pkg::QPTR_W+1)'(dss_pkg::QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (!do_push && do_pop) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_item;
	end

endmodule
`default_nettype wire

// ----- src/dss_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dss_div
// Restoring divider: step length = 256 / tempo, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module dss_div (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [7:0] tempo,
	output logic            done,
	output logic [8:0]      quotient
);

	logic [7:0] dvs_q;
	logic [7:0] rem_q;
	logic [8:0] acc_q;
	logic [3:0] cnt_q;
	logic       busy_q;
	logic       done_q;
	logic [8:0] trial;
	logic       qbit;

	assign trial    = {rem_q, acc_q[8]};
	assign qbit     = (trial >= {1'b0, dvs_q});
	assign done     = done_q;
	assign quotient = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= dss_pkg::DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// tempo 0 counts as 1
			dvs_q <= (tempo == 8'd0) ? 8'd1 : tempo;
			rem_q <= '0;
			acc_q <= dss_pkg::STEP_SCALE;
		end else if (busy_q) begin
			rem_q <= qbit ? 8'(trial - {1'b0, dvs_q}) : trial[7:0];
			acc_q <= {acc_q[7:0], qbit};
		end
	end

endmodule
`default_nettype wire

// ----- src/dss_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dss_back
// Sequencer engine: pattern store, step timing, noise LFSR, result register.
// ----------------------------------------------------------------------------
module dss_back #(
	parameter int STEP_COUNT = 256
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           pop_valid,
	input  wire dss_pkg::item_t pop_item,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output dss_pkg::result_t    result
);

	localparam int STEP_W = $clog2(STEP_COUNT);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEP_COUNT - 1);

	typedef enum logic [1:0] {ST_SWEEP, ST_IDLE, ST_READ, ST_DIV} state_t;

	state_t            state_q;
	logic [7:0]        store_q [STEP_COUNT];
	logic [7:0]        rd_q;
	logic [STEP_W-1:0] cur_q;
	logic [STEP_W-1:0] sweep_q;
	logic [7:0]        tempo_q;
	logic              pend_ok_q;
	logic [7:0]        pend_pat_q;
	logic [7:0]        pend_tempo_q;
	logic [7:0]        ticks_q;
	logic [15:0]       lfsr_q;
	logic [3:0]        drum_q;
	logic              noise_q;
	logic              cleared_q;
	logic              out_valid_q;
	dss_pkg::result_t  res_q;

	logic              start;
	logic              fb;
	logic              fill;
	logic [7:0]        pat;
	logic              clr;
	logic [7:0]        tempo_new;
	logic              div_done;
	logic [8:0]        div_quo;
	logic              div_start;
	logic              wr_en;
	logic [STEP_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic [STEP_W+7:0] cur_ext;

	function automatic logic [STEP_W-1:0] next_step(input logic [STEP_W-1:0] s);
		return (s == LAST_STEP) ? '0 : s + 1'b1;
	endfunction

	assign start     = (state_q == ST_IDLE) && pop_valid && (!out_valid_q || out_ready);
	assign pop       = start;
	assign fb        = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
	assign fill      = pend_ok_q && (rd_q == 8'd0);
	assign pat       = fill ? pend_pat_q : rd_q;
	assign clr       = pat[0];
	assign div_start = (state_q == ST_READ);
	assign cur_ext   = {8'd0, cur_q};
	assign out_valid = out_valid_q;
	assign result    = res_q;

	always_comb begin
		tempo_new = tempo_q;
		if (fill && pend_tempo_q != 8'd0) tempo_new = {pend_tempo_q[6:0], 1'b0};
		if (clr) tempo_new = dss_pkg::TEMPO_RESET;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = pend_pat_q;
		if (state_q == ST_SWEEP) begin
			wr_en   = 1'b1;
			wr_addr = sweep_q;
			wr_data = 8'd0;
		end else if (state_q == ST_READ && fill) begin
			wr_en = 1'b1;
		end
	end

	dss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.tempo    (tempo_new),
		.done     (div_done),
		.quotient (div_quo)
	);

	// pattern store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) store_q[wr_addr] <= wr_data;
		rd_q <= store_q[cur_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_q      <= '0;
			cur_q        <= '0;
			tempo_q      <= dss_pkg::TEMPO_RESET;
			pend_ok_q    <= 1'b0;
			pend_pat_q   <= '0;
			pend_tempo_q <= '0;
			ticks_q      <= '0;
			lfsr_q       <= dss_pkg::NOISE_SEED;
			drum_q       <= '0;
			noise_q      <= 1'b0;
			cleared_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_SWEEP: begin
					sweep_q <= next_step(sweep_q);
					if (sweep_q == LAST_STEP) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						if (pop_item.is_cmd) begin
							pend_ok_q    <= pop_item.marker_ok;
							pend_pat_q   <= pop_item.pattern;
							pend_tempo_q <= pop_item.tempo;
							out_valid_q  <= 1'b1;
						end else begin
							lfsr_q  <= {fb, lfsr_q[15:1]};
							noise_q <= fb;
							if (ticks_q != 8'd0) begin
								ticks_q     <= ticks_q - 1'b1;
								out_valid_q <= 1'b1;
								if (ticks_q == 8'd1) cur_q <= next_step(cur_q);
							end else begin
								state_q <= ST_READ;
							end
						end
					end
				end
				ST_READ: begin
					pend_ok_q    <= 1'b0;
					pend_pat_q   <= '0;
					pend_tempo_q <= '0;
					tempo_q      <= tempo_new;
					cleared_q    <= clr;
					drum_q       <= clr ? 4'd0 : {pat[5], pat[4], pat[3], pat[1]};
					if (clr) cur_q <= next_step(cur_q);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						ticks_q     <= 8'(div_quo - 9'd1);
						out_valid_q <= 1'b1;
						if (div_quo == 9'd1) cur_q <= next_step(cur_q);
						sweep_q <= '0;
						state_q <= cleared_q ? ST_SWEEP : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register: loaded in the cycle an item finishes
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			res_q.step_number   <= cur_ext[7:0];
			res_q.bar_marker    <= (cur_q == '0);
			res_q.tom_on        <= drum_q[0];
			res_q.hat_on        <= drum_q[1];
			res_q.snare_on      <= drum_q[2];
			res_q.bass_on       <= drum_q[3];
			res_q.noise_out     <= pop_item.is_cmd ? noise_q : fb;
			res_q.step_began    <= 1'b0;
			res_q.store_cleared <= 1'b0;
		end else if (state_q == ST_DIV && div_done) begin
			res_q.step_number   <= cur_ext[7:0];
			res_q.bar_marker    <= (cur_q == '0);
			res_q.tom_on        <= drum_q[0];
			res_q.hat_on        <= drum_q[1];
			res_q.snare_on      <= drum_q[2];
			res_q.bass_on       <= drum_q[3];
			res_q.noise_out     <= noise_q;
			res_q.step_began    <= 1'b1;
			res_q.store_cleared <= cleared_q;
		end
	end

endmodule
`default_nettype wire

// ----- src/drum_step_sequencer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drum_step_sequencer_top
// Drum step sequencer: pattern store played step by step on timer ticks.
// ----------------------------------------------------------------------------
// Every input item (a timer tick or a three-byte command) gives exactly one
// result item. A command, or a tick inside a running step, passes from
// input to result through the input register, the queue and the engine.
// A tick that starts a step reads the pattern store (one registered read)
// and then runs the step length 256/tempo through a bit-serial divider.
// A step whose pattern has bit 0 set wipes the store: its result comes out
// first, then a clearing pass over all STEP_COUNT entries, one entry a
// cycle, holds the engine. The same pass runs after reset before the first
// item is carried out; items are taken into the queue meanwhile.
// ----------------------------------------------------------------------------
module drum_step_sequencer_top #(
	parameter int STEP_COUNT = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input channel
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       action,
	input  wire logic [7:0] cmd_marker,
	input  wire logic [7:0] cmd_pattern,
	input  wire logic [7:0] cmd_tempo,
	// result channel
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      step_number,
	output logic            tom_on,
	output logic            hat_on,
	output logic            snare_on,
	output logic            bass_on,
	output logic            noise_out,
	output logic            bar_marker,
	output logic            step_began,
	output logic            store_cleared
);

	logic             push_valid;
	logic             push_ready;
	dss_pkg::item_t   push_item;
	logic             pop_valid;
	logic             pop;
	dss_pkg::item_t   pop_item;
	dss_pkg::result_t result;

	// front: register and tag each item
	dss_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.cmd_marker  (cmd_marker),
		.cmd_pattern (cmd_pattern),
		.cmd_tempo   (cmd_tempo),
		.push_valid  (push_valid),
		.push_item   (push_item),
		.push_ready  (push_ready)
	);

	// queue: lets the front keep taking items during a long step start or sweep
	dss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop        (pop)
	);

	// back: the sequencer itself
	dss_back #(
		.STEP_COUNT (STEP_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	assign step_number   = result.step_number;
	assign tom_on        = result.tom_on;
	assign hat_on        = result.hat_on;
	assign snare_on      = result.snare_on;
	assign bass_on       = result.bass_on;
	assign noise_out     = result.noise_out;
	assign bar_marker    = result.bar_marker;
	assign step_began    = result.step_began;
	assign store_cleared = result.store_cleared;

endmodule
`default_nettype wire

// ----- src/dss_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dss_checker
// Port-level checks of the drum step sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module dss_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       action,
	input wire logic [7:0] cmd_marker,
	input wire logic [7:0] cmd_pattern,
	input wire logic [7:0] cmd_tempo,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] step_number,
	input wire logic       tom_on,
	input wire logic       hat_on,
	input wire logic       snare_on,
	input wire logic       bass_on,
	input wire logic       noise_out,
	input wire logic       bar_marker,
	input wire logic       step_began,
	input wire logic       store_cleared
);

	// a waiting input item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(action) && $stable(cmd_marker)
			&& $stable(cmd_pattern) && $stable(cmd_tempo))
		else $error("input item changed while waiting");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(step_number)
			&& $stable(step_began) && $stable(noise_out))
		else $error("result changed while stalled");

	// a clear step starts a new, silent step
	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && store_cleared |-> step_began && !tom_on && !hat_on
			&& !snare_on && !bass_on)
		else $error("clear step with triggers or without step start");

	// step zero shows as zero
	a_bar_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bar_marker |-> step_number == 8'd0)
		else $error("bar marker on nonzero step");

	// no result is shown when reset is released
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result present right after reset");

endmodule

bind drum_step_sequencer_top dss_checker u_dss_checker (.*);
`default_nettype wire
